// File: rtl/anff_pkg.sv
`timescale 1ns / 1ps

package anff_pkg;

  // Window geometry
  localparam int unsigned WIN_DEPTH  = 16;
  localparam int unsigned START_LEN  = 16;
  localparam int unsigned CMD_LEN    = 8;
  localparam int unsigned FILL_W     = 5;
  localparam int unsigned IDX_W      = 4;

  // Frame markers and command codes
  localparam logic [7:0]  START_MARK = 8'hBF;
  localparam logic [7:0]  CMD_MARK   = 8'hFA;
  localparam logic [31:0] RESET_SEQ  = 32'hFFFF_DEAD;
  localparam logic [7:0]  ALT_MARK   = 8'hFE;
  localparam logic [31:0] ALT_MASK   = 32'h00FF_FFFF;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_RETX  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_ALT   = 2'd3
  } frame_kind_t;

endpackage

// File: rtl/ack_nack_frame_finder_top.sv
`timescale 1ns / 1ps

// Pipeline: each accepted byte transaction is captured in the byte register; its result is
//   then captured in the result register, which drives the outputs.
// Throughput: one byte per cycle; the byte register and the result register are separated
//   by one window update and a 16-byte XOR check, so a new byte is taken every cycle while
//   out_ready is high. A result held by out_ready low stalls the byte register.
// Reset (rst_n low, synchronous): window cleared, fill count zero, start flag cleared
//   (hunting the start ack), both pipeline registers empty.
module ack_nack_frame_finder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  anff_pkg::byte_t     in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_frame_kind,
  output logic [31:0]         out_sequence_res,
  output logic [15:0]         out_byte_count,
  output logic [63:0]         out_timestamp,
  output logic [23:0]         out_alt_command
);
  import anff_pkg::*;

  // Input register
  logic                 s1_valid_r;
  byte_t                s1_byte_r;
  logic                 s1_fire;

  // Frame state
  byte_t                win_r   [WIN_DEPTH];
  byte_t                win_nxt [WIN_DEPTH];
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic                 started_r, started_nxt;

  // Result register
  logic                 out_valid_r;
  frame_kind_t          kind_r;
  logic [31:0]          seq_r;
  logic [15:0]          len_r;
  logic [63:0]          stamp_r;
  logic [23:0]          alt_r;

  // Combinational work
  byte_t                w [WIN_DEPTH];
  logic [IDX_W-1:0]     wr_idx;
  logic [FILL_W-1:0]    cnt;
  byte_t                xor7, xor15;
  logic                 start_hit, cmd_hit, full_miss;
  logic [31:0]          seq_c;
  logic [15:0]          len_c;
  logic [63:0]          stamp_c;
  frame_kind_t          kind_c;
  logic [23:0]          alt_c;

  // Stage 1 advances when the result register can take whatever it yields
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Store the new byte at the fill position (clamped to the last entry)
  always_comb begin
    wr_idx = fill_r[FILL_W-1] ? IDX_W'(WIN_DEPTH - 1) : fill_r[IDX_W-1:0];
    cnt    = {1'b0, wr_idx} + FILL_W'(1);
    for (int i = 0; i < WIN_DEPTH; i++) begin
      w[i] = (IDX_W'(i) == wr_idx) ? s1_byte_r : win_r[i];
    end
  end

  // Check bytes over the command and start spans
  always_comb begin
    xor7  = '0;
    xor15 = '0;
    for (int i = 0; i < CMD_LEN - 1; i++) begin
      xor7 = xor7 ^ w[i];
    end
    for (int i = 0; i < START_LEN - 1; i++) begin
      xor15 = xor15 ^ w[i];
    end
  end

  // Frame match and field extraction
  always_comb begin
    start_hit = !started_r && (cnt == FILL_W'(START_LEN)) &&
                (w[0] == START_MARK) && (xor15 == w[START_LEN-1]);
    cmd_hit   = started_r && (cnt >= FILL_W'(CMD_LEN)) &&
                (w[0] == CMD_MARK) && (xor7 == w[CMD_LEN-1]);
    full_miss = started_r ? ((cnt >= FILL_W'(CMD_LEN)) && !cmd_hit)
                          : ((cnt == FILL_W'(START_LEN)) && !start_hit);
    seq_c   = {w[1], w[2], w[3], w[4]};
    len_c   = {w[5], w[6]};
    stamp_c = {w[7], w[8], w[9], w[10], w[11], w[12], w[13], w[14]};
    alt_c   = '0;
    if (!started_r) begin
      kind_c = KIND_START;
    end else if (seq_c == RESET_SEQ) begin
      kind_c = KIND_RESET;
    end else if (seq_c[31:24] == ALT_MARK) begin
      kind_c = KIND_ALT;
      alt_c  = 24'(seq_c & ALT_MASK);
    end else begin
      kind_c = KIND_RETX;
    end
  end

  // Next window state
  always_comb begin
    win_nxt     = w;
    fill_nxt    = cnt;
    started_nxt = started_r;
    if (start_hit || cmd_hit) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_nxt[i] = '0;
      end
      fill_nxt    = '0;
      started_nxt = 1'b1;
    end else if (full_miss) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_nxt[i] = w[i+1];
      end
      win_nxt[WIN_DEPTH-1] = '0;
      fill_nxt = cnt - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
      fill_r    <= '0;
      started_r <= 1'b0;
    end else if (s1_fire) begin
      win_r     <= win_nxt;
      fill_r    <= fill_nxt;
      started_r <= started_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= start_hit || cmd_hit;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (start_hit || cmd_hit)) begin
      kind_r  <= kind_c;
      seq_r   <= seq_c;
      len_r   <= len_c;
      stamp_r <= start_hit ? stamp_c : 64'd0;
      alt_r   <= alt_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_kind   = kind_r;
  assign out_sequence_res = seq_r;
  assign out_byte_count   = len_r;
  assign out_timestamp    = stamp_r;
  assign out_alt_command  = alt_r;

  // Once the start ack is seen the block never returns to start hunting
  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("start flag cleared without reset");

  // After start the window never holds a full command frame between bytes
  a_cmd_fill: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (fill_r < FILL_W'(CMD_LEN)))
    else $error("window fill beyond command length after start");

  // Start flag rises together with a start ack result
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(started_r) |-> (out_valid_r && (kind_r == KIND_START)))
    else $error("start flag set without start ack result");

  // Command results carry no timestamp
  a_cmd_no_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r != KIND_START)) |-> (stamp_r == 64'd0))
    else $error("timestamp on command result");

  // Alternate payload only on alternate commands
  a_alt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r != KIND_ALT)) |-> (alt_r == 24'd0))
    else $error("alternate payload on other frame kind");

endmodule
